// ===== design/assert_macros.svh =====
// assertion macros shared by the grid test pattern rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GTP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GTP_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define GTP_ASSERT(label, clk, rst_n, prop, msg)
`define GTP_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== design/gtp_pkg.sv =====
// types and constants of the grid test pattern colour unit
`timescale 1ns / 1ps
`default_nettype none

package gtp_pkg;

  localparam int CoordWidth   = 12;
  localparam int ResWidth     = 12;
  localparam int CountWidth   = 8;
  localparam int ColorWidth   = 32;
  localparam int StepWidth    = 8;
  localparam int BppWidth     = 3;
  localparam int LayoutWidth  = 48;
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 48;
  localparam int ByteWidth    = 8;
  localparam int PosWidth     = 5;

  localparam int CmpWidth   = (CoordWidth > ResWidth) ? CoordWidth : ResWidth;
  localparam int DivWidth   = CmpWidth + CountWidth;
  localparam int HalfBits   = CountWidth / 2;
  localparam int DivCntWidth = $clog2(ResWidth);
  localparam int IdxWidth   = 2 * CountWidth;
  localparam int IncWidth   = CountWidth + 1 + StepWidth;
  localparam int IStepWidth = IdxWidth + StepWidth;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegHRes,
    RegVRes,
    RegRectCount,
    RegFirstColor,
    RegColorStep,
    RegIndexedMode,
    RegBpp,
    RegFieldLayout
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CfgLoad,
    CfgDivide,
    CfgFinish,
    CfgIdle
  } cfg_state_e;

  typedef struct packed {
    logic [ColorWidth-1:0] mask;
    logic [ColorWidth-1:0] base;
    logic [PosWidth-1:0]   pos;
    logic                  pos_ok;
  } field_t;

  typedef struct packed {
    logic [ResWidth-1:0]   w;
    logic [ResWidth-1:0]   h;
    logic [ResWidth-1:0]   xlim;
    logic [ResWidth-1:0]   ylim;
    logic [CountWidth-1:0] rc;
    logic [ColorWidth-1:0] first;
    logic [StepWidth-1:0]  step;
    logic                  indexed;
    logic [ColorWidth-1:0] imask;
    field_t                red;
    field_t                green;
    field_t                blue;
  } derived_t;

  typedef struct packed {
    logic [CmpWidth-1:0] rem;
    logic [HalfBits-1:0] q;
  } part_t;

  typedef struct packed {
    logic                  covered;
    logic [CountWidth-1:0] col;
    logic [CountWidth-1:0] row;
  } grid_t;

endpackage

`default_nettype wire

// ===== design/gtp_cfg.sv =====
// configuration registers and derived rectangle geometry of the grid pattern
`timescale 1ns / 1ps
`default_nettype none

module gtp_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [gtp_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  wire logic [gtp_pkg::CfgDataWidth-1:0] cfg_data_i,
  output gtp_pkg::derived_t                     derived_o,
  output logic                                  busy_o
);

  logic [gtp_pkg::ResWidth-1:0]    h_res_q;
  logic [gtp_pkg::ResWidth-1:0]    v_res_q;
  logic [gtp_pkg::CountWidth-1:0]  rect_count_q;
  logic [gtp_pkg::ColorWidth-1:0]  first_color_q;
  logic [gtp_pkg::StepWidth-1:0]   color_step_q;
  logic                            indexed_q;
  logic [gtp_pkg::BppWidth-1:0]    bpp_q;
  logic [gtp_pkg::LayoutWidth-1:0] layout_q;

  gtp_pkg::cfg_state_e state_q, state_d;
  logic [gtp_pkg::DivCntWidth-1:0] cnt_q, cnt_d;
  logic [gtp_pkg::CountWidth-1:0]  remx_q, remx_d, remy_q, remy_d;
  logic [gtp_pkg::ResWidth-1:0]    quox_q, quox_d, quoy_q, quoy_d;
  gtp_pkg::derived_t               derived_q, derived_d;

  logic [gtp_pkg::CountWidth:0]    remx_sh, remy_sh, remx_n, remy_n, rc_ext;
  logic                            bitx, bity;
  logic [gtp_pkg::ResWidth+gtp_pkg::CountWidth-1:0] xprod, yprod;
  logic [gtp_pkg::ColorWidth-1:0]  imask;

  function automatic gtp_pkg::field_t make_field(
    input logic [gtp_pkg::ByteWidth-1:0]  size,
    input logic [gtp_pkg::ByteWidth-1:0]  pos,
    input logic [gtp_pkg::ColorWidth-1:0] first
  );
    gtp_pkg::field_t f;
    if (|size[gtp_pkg::ByteWidth-1:gtp_pkg::PosWidth]) begin
      f.mask = '1;
    end else begin
      f.mask = ~({gtp_pkg::ColorWidth{1'b1}} << size[gtp_pkg::PosWidth-1:0]);
    end
    f.pos    = pos[gtp_pkg::PosWidth-1:0];
    f.pos_ok = ~|pos[gtp_pkg::ByteWidth-1:gtp_pkg::PosWidth];
    f.base   = (first >> pos[gtp_pkg::PosWidth-1:0]) & f.mask;
    return f;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_res_q       <= gtp_pkg::ResWidth'(1024);
      v_res_q       <= gtp_pkg::ResWidth'(768);
      rect_count_q  <= gtp_pkg::CountWidth'(1);
      first_color_q <= '0;
      color_step_q  <= '0;
      indexed_q     <= 1'b1;
      bpp_q         <= gtp_pkg::BppWidth'(1);
      layout_q      <= '0;
    end else if (cfg_we_i) begin
      case (gtp_pkg::cfg_reg_e'(cfg_idx_i))
        gtp_pkg::RegHRes:        h_res_q       <= cfg_data_i[gtp_pkg::ResWidth-1:0];
        gtp_pkg::RegVRes:        v_res_q       <= cfg_data_i[gtp_pkg::ResWidth-1:0];
        gtp_pkg::RegRectCount:   rect_count_q  <= cfg_data_i[gtp_pkg::CountWidth-1:0];
        gtp_pkg::RegFirstColor:  first_color_q <= cfg_data_i[gtp_pkg::ColorWidth-1:0];
        gtp_pkg::RegColorStep:   color_step_q  <= cfg_data_i[gtp_pkg::StepWidth-1:0];
        gtp_pkg::RegIndexedMode: indexed_q     <= cfg_data_i[0];
        gtp_pkg::RegBpp:         bpp_q         <= cfg_data_i[gtp_pkg::BppWidth-1:0];
        gtp_pkg::RegFieldLayout: layout_q      <= cfg_data_i[gtp_pkg::LayoutWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gtp_pkg::CfgLoad;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    remx_q    <= remx_d;
    remy_q    <= remy_d;
    quox_q    <= quox_d;
    quoy_q    <= quoy_d;
    derived_q <= derived_d;
  end

  always_comb begin
    rc_ext  = {1'b0, rect_count_q};
    remx_sh = {remx_q, quox_q[gtp_pkg::ResWidth-1]};
    remy_sh = {remy_q, quoy_q[gtp_pkg::ResWidth-1]};
    bitx    = remx_sh >= rc_ext;
    bity    = remy_sh >= rc_ext;
    remx_n  = bitx ? remx_sh - rc_ext : remx_sh;
    remy_n  = bity ? remy_sh - rc_ext : remy_sh;
    xprod   = (gtp_pkg::ResWidth+gtp_pkg::CountWidth)'(rect_count_q)
            * (gtp_pkg::ResWidth+gtp_pkg::CountWidth)'(quox_q);
    yprod   = (gtp_pkg::ResWidth+gtp_pkg::CountWidth)'(rect_count_q)
            * (gtp_pkg::ResWidth+gtp_pkg::CountWidth)'(quoy_q);
    case (bpp_q)
      gtp_pkg::BppWidth'(0): imask = '0;
      gtp_pkg::BppWidth'(1): imask = gtp_pkg::ColorWidth'(32'h0000_00FF);
      gtp_pkg::BppWidth'(2): imask = gtp_pkg::ColorWidth'(32'h0000_FFFF);
      gtp_pkg::BppWidth'(3): imask = gtp_pkg::ColorWidth'(32'h00FF_FFFF);
      default:               imask = '1;
    endcase

    state_d   = state_q;
    cnt_d     = cnt_q;
    remx_d    = remx_q;
    remy_d    = remy_q;
    quox_d    = quox_q;
    quoy_d    = quoy_q;
    derived_d = derived_q;

    case (state_q)
      gtp_pkg::CfgLoad: begin
        remx_d  = '0;
        remy_d  = '0;
        quox_d  = h_res_q;
        quoy_d  = v_res_q;
        cnt_d   = '0;
        state_d = gtp_pkg::CfgDivide;
      end
      gtp_pkg::CfgDivide: begin
        remx_d = remx_n[gtp_pkg::CountWidth-1:0];
        remy_d = remy_n[gtp_pkg::CountWidth-1:0];
        quox_d = {quox_q[gtp_pkg::ResWidth-2:0], bitx};
        quoy_d = {quoy_q[gtp_pkg::ResWidth-2:0], bity};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == gtp_pkg::DivCntWidth'(gtp_pkg::ResWidth - 1)) begin
          state_d = gtp_pkg::CfgFinish;
        end
      end
      gtp_pkg::CfgFinish: begin
        derived_d.w       = quox_q;
        derived_d.h       = quoy_q;
        derived_d.xlim    = xprod[gtp_pkg::ResWidth-1:0];
        derived_d.ylim    = yprod[gtp_pkg::ResWidth-1:0];
        derived_d.rc      = rect_count_q;
        derived_d.first   = first_color_q;
        derived_d.step    = color_step_q;
        derived_d.indexed = indexed_q;
        derived_d.imask   = imask;
        derived_d.red     = make_field(layout_q[7:0], layout_q[15:8], first_color_q);
        derived_d.green   = make_field(layout_q[23:16], layout_q[31:24], first_color_q);
        derived_d.blue    = make_field(layout_q[39:32], layout_q[47:40], first_color_q);
        state_d           = gtp_pkg::CfgIdle;
      end
      gtp_pkg::CfgIdle: ;
      default: state_d = gtp_pkg::CfgLoad;
    endcase

    if (cfg_we_i) begin
      state_d = gtp_pkg::CfgLoad;
    end
  end

  assign derived_o = derived_q;
  assign busy_o    = (state_q != gtp_pkg::CfgIdle);

endmodule

`default_nettype wire

// ===== design/gtp_div.sv =====
// coordinate to rectangle index stages of the grid pattern
`timescale 1ns / 1ps
`default_nettype none

module gtp_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire logic [gtp_pkg::CoordWidth-1:0] pixel_x_i,
  input  wire logic [gtp_pkg::CoordWidth-1:0] pixel_y_i,
  input  wire gtp_pkg::derived_t              cfg_i,
  output logic                                out_valid_o,
  output gtp_pkg::grid_t                      grid_o
);

  logic                           v0_q, v1_q, v2_q;
  logic [gtp_pkg::CoordWidth-1:0] px0_q, py0_q;
  logic                           cov1_q;
  gtp_pkg::part_t                 x1_q, y1_q, x1_d, y1_d, x2_d, y2_d;
  gtp_pkg::grid_t                 grid2_q, grid2_d;
  logic                           cov1_d;

  function automatic gtp_pkg::part_t div_half(
    input logic [gtp_pkg::CmpWidth-1:0] rem,
    input logic [gtp_pkg::ResWidth-1:0] divisor,
    input logic                         upper
  );
    logic [gtp_pkg::DivWidth-1:0] r;
    logic [gtp_pkg::DivWidth-1:0] t;
    gtp_pkg::part_t               res;
    r     = gtp_pkg::DivWidth'(rem);
    res.q = '0;
    for (int k = gtp_pkg::HalfBits - 1; k >= 0; k--) begin
      t = gtp_pkg::DivWidth'(divisor) << (upper ? k + gtp_pkg::HalfBits : k);
      if (r >= t) begin
        r        = r - t;
        res.q[k] = 1'b1;
      end
    end
    res.rem = r[gtp_pkg::CmpWidth-1:0];
    return res;
  endfunction

  always_comb begin
    cov1_d = (gtp_pkg::CmpWidth'(px0_q) < gtp_pkg::CmpWidth'(cfg_i.xlim))
          && (gtp_pkg::CmpWidth'(py0_q) < gtp_pkg::CmpWidth'(cfg_i.ylim));
    x1_d   = div_half(gtp_pkg::CmpWidth'(px0_q), cfg_i.w, 1'b1);
    y1_d   = div_half(gtp_pkg::CmpWidth'(py0_q), cfg_i.h, 1'b1);
    x2_d   = div_half(x1_q.rem, cfg_i.w, 1'b0);
    y2_d   = div_half(y1_q.rem, cfg_i.h, 1'b0);
    grid2_d.covered = cov1_q;
    grid2_d.col     = {x1_q.q, x2_d.q};
    grid2_d.row     = {y1_q.q, y2_d.q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    px0_q   <= pixel_x_i;
    py0_q   <= pixel_y_i;
    cov1_q  <= cov1_d;
    x1_q    <= x1_d;
    y1_q    <= y1_d;
    grid2_q <= grid2_d;
  end

  assign out_valid_o = v2_q;
  assign grid_o      = grid2_q;

endmodule

`default_nettype wire

// ===== design/gtp_color.sv =====
// colour stages of the grid pattern: products, field update, output register
`timescale 1ns / 1ps
`default_nettype none

module gtp_color (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire gtp_pkg::grid_t                 grid_i,
  input  wire gtp_pkg::derived_t              cfg_i,
  output logic                                valid_o,
  output logic                                covered_o,
  output logic [gtp_pkg::ColorWidth-1:0]      pixel_color_o,
  output logic [gtp_pkg::CountWidth-1:0]      rect_column_o,
  output logic [gtp_pkg::CountWidth-1:0]      rect_row_o
);

  logic                             v3_q, v4_q, v5_q;
  gtp_pkg::grid_t                   g3_q, g4_q;
  logic [gtp_pkg::IdxWidth-1:0]     prc3_q;
  logic [gtp_pkg::IncWidth-1:0]     pc3_q, pr3_q, ps3_q;
  logic [gtp_pkg::IStepWidth-1:0]   istep4_q;
  logic [gtp_pkg::ColorWidth-1:0]   fr4_q, fg4_q, fb4_q;
  logic                             cov5_q;
  logic [gtp_pkg::ColorWidth-1:0]   color5_q;
  logic [gtp_pkg::CountWidth-1:0]   col5_q, row5_q;

  logic [gtp_pkg::CountWidth:0]     rc_sum;
  logic [gtp_pkg::IdxWidth-1:0]     idx;
  logic [gtp_pkg::ColorWidth-1:0]   color_d;

  function automatic logic [gtp_pkg::ColorWidth-1:0] field_val(
    input gtp_pkg::field_t              f,
    input logic [gtp_pkg::IncWidth-1:0] inc
  );
    logic [gtp_pkg::ColorWidth-1:0] s;
    s = (f.base + gtp_pkg::ColorWidth'(inc)) & f.mask;
    return f.pos_ok ? (s << f.pos) : '0;
  endfunction

  always_comb begin
    rc_sum = {1'b0, grid_i.row} + {1'b0, grid_i.col};
    idx    = prc3_q + gtp_pkg::IdxWidth'(g3_q.col);
    if (cfg_i.indexed) begin
      color_d = (cfg_i.first + gtp_pkg::ColorWidth'(istep4_q)) & cfg_i.imask;
    end else begin
      color_d = fr4_q | fg4_q | fb4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v3_q <= in_valid_i;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // products of the rectangle indices
  always_ff @(posedge clk_i) begin
    g3_q   <= grid_i;
    prc3_q <= gtp_pkg::IdxWidth'(grid_i.row) * gtp_pkg::IdxWidth'(cfg_i.rc);
    pc3_q  <= gtp_pkg::IncWidth'(grid_i.col) * gtp_pkg::IncWidth'(cfg_i.step);
    pr3_q  <= gtp_pkg::IncWidth'(grid_i.row) * gtp_pkg::IncWidth'(cfg_i.step);
    ps3_q  <= gtp_pkg::IncWidth'(rc_sum) * gtp_pkg::IncWidth'(cfg_i.step);
  end

  always_ff @(posedge clk_i) begin
    g4_q     <= g3_q;
    istep4_q <= gtp_pkg::IStepWidth'(idx) * gtp_pkg::IStepWidth'(cfg_i.step);
    fr4_q    <= field_val(cfg_i.red, pc3_q);
    fg4_q    <= field_val(cfg_i.green, pr3_q);
    fb4_q    <= field_val(cfg_i.blue, ps3_q);
  end

  // uncovered pixels report zero everywhere
  always_ff @(posedge clk_i) begin
    cov5_q   <= g4_q.covered;
    color5_q <= g4_q.covered ? color_d : '0;
    col5_q   <= g4_q.covered ? g4_q.col : '0;
    row5_q   <= g4_q.covered ? g4_q.row : '0;
  end

  assign valid_o       = v5_q;
  assign covered_o     = cov5_q;
  assign pixel_color_o = color5_q;
  assign rect_column_o = col5_q;
  assign rect_row_o    = row5_q;

endmodule

`default_nettype wire

// ===== design/grid_test_pattern_color_unit.sv =====
// top level of the grid test pattern colour unit
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// A pixel coordinate is taken on pixel_x_i / pixel_y_i at a rising edge where
// start is high and busy is low. Its result (covered, colour, rectangle column
// and row) is shown for one cycle with valid_o high. One item can be taken
// every clock while busy is low: the path is six register stages (input, two
// quotient stages of four bits each, products, field update, output), and
// there is no back pressure since the receiver cannot stall.
// Registers are to be written through cfg_we_i / cfg_idx_i / cfg_data_i
// only while no item is in flight; the block itself does not enforce this.
// Each write, and reset, starts a rebuild of the rectangle size with a one
// bit per cycle divider: busy stays high during the write cycle and until
// that rebuild ends, and no item is taken meanwhile. Reset clears the
// pipeline, loads the register defaults and starts that rebuild.

module grid_test_pattern_color_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             cfg_we_i,
  input  wire logic [gtp_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  wire logic [gtp_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  wire logic [gtp_pkg::CoordWidth-1:0]   pixel_x_i,
  input  wire logic [gtp_pkg::CoordWidth-1:0]   pixel_y_i,
  output logic                                  valid_o,
  output logic                                  covered_o,
  output logic [gtp_pkg::ColorWidth-1:0]        pixel_color_o,
  output logic [gtp_pkg::CountWidth-1:0]        rect_column_o,
  output logic [gtp_pkg::CountWidth-1:0]        rect_row_o
);

  gtp_pkg::derived_t derived;
  gtp_pkg::grid_t    grid;
  logic              cfg_busy;
  logic              accept;
  logic              grid_valid;

  assign busy   = cfg_busy | cfg_we_i;
  assign accept = start & ~busy;

  gtp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .derived_o  (derived),
    .busy_o     (cfg_busy)
  );

  gtp_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .cfg_i       (derived),
    .out_valid_o (grid_valid),
    .grid_o      (grid)
  );

  gtp_color u_color (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (grid_valid),
    .grid_i        (grid),
    .cfg_i         (derived),
    .valid_o       (valid_o),
    .covered_o     (covered_o),
    .pixel_color_o (pixel_color_o),
    .rect_column_o (rect_column_o),
    .rect_row_o    (rect_row_o)
  );

  `GTP_ASSERT(a_latency, clk_i, rst_ni, (start && !busy) |-> ##6 valid_o, "item lost in pipeline")
  `GTP_ASSERT(a_no_extra, clk_i, rst_ni, valid_o |-> $past(start && !busy, 6), "result without item")
  `GTP_ASSERT_NEVER(a_uncov_color, clk_i, rst_ni, valid_o && !covered_o && (pixel_color_o != '0), "uncovered pixel has colour")
  `GTP_ASSERT_NEVER(a_uncov_index, clk_i, rst_ni, valid_o && !covered_o && ((rect_column_o != '0) || (rect_row_o != '0)), "uncovered pixel has index")

endmodule

`default_nettype wire
